FILE: src/usvg_pkg.sv
// Shared constants, types and helpers for the UV sphere vertex generator.
package usvg_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int DIV_STAGES    = 32;
  localparam int ATAN_ENTRIES  = 24;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [7:0] MIN_WIDTH  = 8'd3;
  localparam logic [7:0] MIN_HEIGHT = 8'd2;

  localparam logic signed [63:0] POS_LIM  = 64'sd65535;
  localparam logic signed [63:0] NORM_LIM = 64'sd16384;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
  } cordic_t;

  typedef struct packed {
    logic        oor;
    logic        quad_valid;
    logic        lat_hi;
    logic        lon_hi;
    logic [15:0] vertex_index;
    logic [15:0] below_index;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } meta_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  // Round to nearest, ties up, then drop n fraction bits.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int n);
    logic signed [63:0] half;
    half = 64'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [63:0] sat_lim(input logic signed [63:0] v,
                                                  input logic signed [63:0] lim);
    logic signed [63:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

FILE: src/usvg_div_cell.sv
// One restoring-division step: shift the remainder, subtract the divisor if it fits.
module usvg_div_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  divisor,
  input  logic [7:0]  rem_in,
  input  logic [31:0] quo_in,
  output logic [7:0]  rem_r,
  output logic [31:0] quo_r
);
  import usvg_pkg::*;

  logic [8:0]  trial;
  logic [8:0]  diff;
  logic        fits;
  logic [7:0]  rem_nxt;
  logic [31:0] quo_nxt;

  always_comb begin
    trial   = {rem_in, 1'b0};
    diff    = trial - {1'b0, divisor};
    fits    = trial >= {1'b0, divisor};
    rem_nxt = fits ? diff[7:0] : trial[7:0];
    quo_nxt = {quo_in[30:0], fits};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

FILE: src/usvg_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation on a quarter-turn residue.
module usvg_cordic_cell (
  input  logic                    clk,
  input  logic                    en,
  input  logic [4:0]              stage_idx,
  input  usvg_pkg::cordic_t       cs_in,
  output usvg_pkg::cordic_t       cs_r
);
  import usvg_pkg::*;

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] ang;
  cordic_t            cs_nxt;

  always_comb begin
    dx          = cs_in.y >>> stage_idx;
    dy          = cs_in.x >>> stage_idx;
    ang         = signed'(atan_turn(stage_idx));
    cs_nxt.quad = cs_in.quad;
    if (!cs_in.z[31]) begin
      cs_nxt.x = cs_in.x - dx;
      cs_nxt.y = cs_in.y + dy;
      cs_nxt.z = cs_in.z - ang;
    end else begin
      cs_nxt.x = cs_in.x + dx;
      cs_nxt.y = cs_in.y - dy;
      cs_nxt.z = cs_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= cs_nxt;
    end
  end

endmodule

FILE: src/uv_sphere_vertex_generator.sv
// UV sphere vertex generator: divider chains, CORDIC chains and output math.
// Pipeline: 1 input register, 32 divider cells, 1 phase register, 16 CORDIC cells,
// 4 multiply/round stages and the output register.
// Throughput: one vertex per clock; every stage moves forward each cycle unless the
// last stage is full and the output register holds a word that out_tready does not take.
// Reset: rst_n synchronous, clears the pipeline valids; radius 256, W 32, H 16.
module uv_sphere_vertex_generator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // grid_row[7:0], grid_column[15:8]
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x[16:0], pos_y[33:17], pos_z[50:34], tex_u[67:51], tex_v[84:68],
  // norm_x[100:85], norm_y[116:101], norm_z[132:117], vertex_index[148:133],
  // below_index[164:149], zero[167:165]
  output logic [167:0] out_tdata,
  output logic [1:0]   out_tuser,  // quad_valid[0], out_of_range[1]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import usvg_pkg::*;

  localparam int ST_D  = DIV_STAGES + 1;
  localparam int ST_M0 = ST_D + CORDIC_STAGES + 1;
  localparam int ST_M3 = ST_M0 + 3;
  localparam int NST   = ST_M3 + 1;

  logic [15:0] radius_r;
  logic [7:0]  width_r;
  logic [7:0]  height_r;
  logic [7:0]  w_eff;
  logic [7:0]  h_eff;

  logic        en;
  logic        in_acc;
  logic        out_load;

  logic [NST-1:0] v_r;
  meta_t          meta_r   [NST];
  meta_t          meta_nxt [NST];

  // input stage
  logic [7:0]  row;
  logic [7:0]  col;
  logic [16:0] idx_full;
  logic [7:0]  lat_rem0_r;
  logic [7:0]  lon_rem0_r;
  meta_t       meta_in;

  // divider chains
  logic [7:0]  lat_rem [DIV_STAGES];
  logic [31:0] lat_quo [DIV_STAGES];
  logic [7:0]  lon_rem [DIV_STAGES];
  logic [31:0] lon_quo [DIV_STAGES];

  // phase stage
  logic [31:0] lat_phase;
  logic [31:0] lon_phase;
  logic [17:0] u_sum;
  logic [17:0] v_sum;
  cordic_t     lat_cs_d_r;
  cordic_t     lon_cs_d_r;

  cordic_t     lat_cs [CORDIC_STAGES];
  cordic_t     lon_cs [CORDIC_STAGES];

  // output math
  logic signed [31:0] cl_nxt, sl_nxt, clon_nxt, slon_nxt;
  logic signed [31:0] cl_r, sl_r, clon_r, slon_r;
  logic signed [63:0] pxp_r, pyp_r;
  logic signed [48:0] pzp_r;
  logic signed [31:0] cl_m1_r;
  logic signed [33:0] tx_r, ty_r;
  logic [16:0]        pos_z_m2_r, pos_z_m3_r;
  logic [15:0]        norm_z_m2_r, norm_z_m3_r;
  logic signed [50:0] prx_r, pry_r;
  logic [15:0]        norm_x_r, norm_y_r;
  logic [16:0]        out_pos_x, out_pos_y;

  function automatic cordic_t map_quad(input cordic_t c);
    cordic_t m;
    m = c;
    case (c.quad)
      2'd0: begin m.x = c.x;  m.y = c.y;  end
      2'd1: begin m.x = -c.y; m.y = c.x;  end
      2'd2: begin m.x = -c.x; m.y = -c.y; end
      default: begin m.x = c.y; m.y = -c.x; end
    endcase
    return m;
  endfunction

  // ---------------- configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      width_r  <= 8'd32;
      height_r <= 8'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS: radius_r <= cfg_data;
        REG_WIDTH:  width_r  <= cfg_data[7:0];
        REG_HEIGHT: height_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_r < MIN_WIDTH) ? MIN_WIDTH : width_r;
  assign h_eff = (height_r < MIN_HEIGHT) ? MIN_HEIGHT : height_r;

  // ---------------- flow control
  assign out_load  = !out_tvalid || out_tready;
  assign en        = !v_r[NST-1] || out_load;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_acc};
    end
  end

  // ---------------- input stage
  always_comb begin
    row      = in_tdata[7:0];
    col      = in_tdata[15:8];
    idx_full = row * ({1'b0, w_eff} + 9'd1) + {9'd0, col};
    meta_in.oor          = (row > h_eff) || (col > w_eff);
    meta_in.quad_valid   = (row < h_eff) && (col < w_eff);
    meta_in.lat_hi       = (row == h_eff);
    meta_in.lon_hi       = (col == w_eff);
    meta_in.vertex_index = idx_full[15:0];
    meta_in.below_index  = idx_full[15:0] + {8'd0, w_eff} + 16'd1;
    meta_in.tex_u        = '0;
    meta_in.tex_v        = '0;
  end

  always_comb begin
    meta_nxt[0] = meta_in;
    for (int k = 1; k < NST; k++) begin
      meta_nxt[k] = meta_r[k-1];
    end
    meta_nxt[ST_D].tex_u = u_sum[17:1];
    meta_nxt[ST_D].tex_v = v_sum[17:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        meta_r[k] <= meta_nxt[k];
      end
      // start the remainder at the numerator; n == d or an off-grid word starts at zero
      lat_rem0_r <= (meta_in.oor || meta_in.lat_hi) ? 8'd0 : row;
      lon_rem0_r <= (meta_in.oor || meta_in.lon_hi) ? 8'd0 : col;
    end
  end

  // ---------------- divider chains: floor(n * 2^32 / d)
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    usvg_div_cell u_lat (
      .clk     (clk),
      .en      (en),
      .divisor (h_eff),
      .rem_in  ((i == 0) ? lat_rem0_r : lat_rem[(i == 0) ? 0 : i-1]),
      .quo_in  ((i == 0) ? 32'd0 : lat_quo[(i == 0) ? 0 : i-1]),
      .rem_r   (lat_rem[i]),
      .quo_r   (lat_quo[i])
    );
    usvg_div_cell u_lon (
      .clk     (clk),
      .en      (en),
      .divisor (w_eff),
      .rem_in  ((i == 0) ? lon_rem0_r : lon_rem[(i == 0) ? 0 : i-1]),
      .quo_in  ((i == 0) ? 32'd0 : lon_quo[(i == 0) ? 0 : i-1]),
      .rem_r   (lon_rem[i]),
      .quo_r   (lon_quo[i])
    );
  end

  // ---------------- phase stage
  always_comb begin
    lat_phase = {meta_r[ST_D-1].lat_hi, lat_quo[DIV_STAGES-1][31:1]};
    lon_phase = lon_quo[DIV_STAGES-1];
    // round(n * 2^16 / d) from floor(n * 2^17 / d)
    u_sum = {meta_r[ST_D-1].lon_hi, lon_quo[DIV_STAGES-1][31:15]} + 18'd1;
    v_sum = {meta_r[ST_D-1].lat_hi, lat_quo[DIV_STAGES-1][31:15]} + 18'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat_cs_d_r.x    <= CORDIC_GAIN;
      lat_cs_d_r.y    <= '0;
      lat_cs_d_r.z    <= {2'b00, lat_phase[29:0]};
      lat_cs_d_r.quad <= lat_phase[31:30];
      lon_cs_d_r.x    <= CORDIC_GAIN;
      lon_cs_d_r.y    <= '0;
      lon_cs_d_r.z    <= {2'b00, lon_phase[29:0]};
      lon_cs_d_r.quad <= lon_phase[31:30];
    end
  end

  // ---------------- CORDIC chains
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    usvg_cordic_cell u_lat (
      .clk       (clk),
      .en        (en),
      .stage_idx (5'(i)),
      .cs_in     ((i == 0) ? lat_cs_d_r : lat_cs[(i == 0) ? 0 : i-1]),
      .cs_r      (lat_cs[i])
    );
    usvg_cordic_cell u_lon (
      .clk       (clk),
      .en        (en),
      .stage_idx (5'(i)),
      .cs_in     ((i == 0) ? lon_cs_d_r : lon_cs[(i == 0) ? 0 : i-1]),
      .cs_r      (lon_cs[i])
    );
  end

  // ---------------- quadrant fold, products, rounding
  always_comb begin
    cordic_t ml;
    cordic_t mo;
    ml       = map_quad(lat_cs[CORDIC_STAGES-1]);
    mo       = map_quad(lon_cs[CORDIC_STAGES-1]);
    cl_nxt   = ml.x;
    sl_nxt   = ml.y;
    clon_nxt = mo.x;
    slon_nxt = mo.y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // M0
      cl_r   <= cl_nxt;
      sl_r   <= sl_nxt;
      clon_r <= clon_nxt;
      slon_r <= slon_nxt;
      // M1
      pxp_r   <= sl_r * clon_r;
      pyp_r   <= sl_r * slon_r;
      pzp_r   <= $signed({1'b0, radius_r}) * cl_r;
      cl_m1_r <= cl_r;
      // M2
      tx_r        <= 34'(rnd_shift(pxp_r, 30));
      ty_r        <= 34'(rnd_shift(pyp_r, 30));
      pos_z_m2_r  <= 17'(sat_lim(rnd_shift(64'(pzp_r), 30), POS_LIM));
      norm_z_m2_r <= 16'(sat_lim(rnd_shift(64'(cl_m1_r), 16), NORM_LIM));
      // M3
      prx_r       <= $signed({1'b0, radius_r}) * tx_r;
      pry_r       <= $signed({1'b0, radius_r}) * ty_r;
      norm_x_r    <= 16'(sat_lim(rnd_shift(64'(tx_r), 16), NORM_LIM));
      norm_y_r    <= 16'(sat_lim(rnd_shift(64'(ty_r), 16), NORM_LIM));
      pos_z_m3_r  <= pos_z_m2_r;
      norm_z_m3_r <= norm_z_m2_r;
    end
  end

  assign out_pos_x = 17'(sat_lim(rnd_shift(64'(prx_r), 30), POS_LIM));
  assign out_pos_y = 17'(sat_lim(rnd_shift(64'(pry_r), 30), POS_LIM));

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (out_load) begin
      out_tvalid <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && v_r[NST-1]) begin
      if (meta_r[NST-1].oor) begin
        out_tdata <= '0;
        out_tuser <= 2'b10;
      end else begin
        out_tdata <= {3'b000,
                      meta_r[NST-1].below_index,
                      meta_r[NST-1].vertex_index,
                      norm_z_m3_r, norm_y_r, norm_x_r,
                      meta_r[NST-1].tex_v, meta_r[NST-1].tex_u,
                      pos_z_m3_r, out_pos_y, out_pos_x};
        out_tuser <= {1'b0, meta_r[NST-1].quad_valid};
      end
    end
  end

`ifndef SYNTHESIS
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == '0))
    else $error("off-grid word carries nonzero fields");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("quad_valid and out_of_range both set");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted word missing from first stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NST-1] && out_tvalid && !out_tready) |=> (v_r[NST-1] && $stable(meta_r[NST-1])))
    else $error("last stage dropped while output stalled");
`endif

endmodule
